// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property only on edges where a word is presented.
`define CHK_ASSERT_VLD(lbl, clk, rst_n, vld, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld) |-> (prop)) else $error(msg);

`endif

// File: design/chc_pkg.sv
package chc_pkg;

	// Checksum window over the header
	localparam logic [8:0] SUM_FIRST = 9'h134;
	localparam logic [8:0] SUM_LAST  = 9'h14C;

	// ROM size codes at or above this value are invalid
	localparam logic [7:0] ROM_CODE_LIMIT = 8'h09;
	localparam logic [23:0] ROM_BASE_BYTES = 24'd32768;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_TYPE_OFS = 2'd0;
	localparam logic [1:0] REG_ROM_OFS  = 2'd1;
	localparam logic [1:0] REG_RAM_OFS  = 2'd2;
	localparam logic [1:0] REG_SUM_OFS  = 2'd3;

	// Register reset values
	localparam logic [8:0] RST_TYPE_OFS = 9'h147;
	localparam logic [8:0] RST_ROM_OFS  = 9'h148;
	localparam logic [8:0] RST_RAM_OFS  = 9'h149;
	localparam logic [8:0] RST_SUM_OFS  = 9'h14D;

	// Mapper kinds
	localparam logic [2:0] MK_NONE        = 3'd0;
	localparam logic [2:0] MK_MBC1        = 3'd1;
	localparam logic [2:0] MK_MBC2        = 3'd2;
	localparam logic [2:0] MK_MBC3        = 3'd3;
	localparam logic [2:0] MK_MBC5        = 3'd4;
	localparam logic [2:0] MK_UNSUPPORTED = 3'd5;

	// Cartridge type codes
	localparam logic [7:0] CT_ROM_ONLY      = 8'h00;
	localparam logic [7:0] CT_MBC1          = 8'h01;
	localparam logic [7:0] CT_MBC1_RAM      = 8'h02;
	localparam logic [7:0] CT_MBC1_RAM_BAT  = 8'h03;
	localparam logic [7:0] CT_MBC2          = 8'h05;
	localparam logic [7:0] CT_MBC2_BAT      = 8'h06;
	localparam logic [7:0] CT_MBC3_TIM_BAT  = 8'h0F;
	localparam logic [7:0] CT_MBC3_TIM_RAM_BAT = 8'h10;
	localparam logic [7:0] CT_MBC3          = 8'h11;
	localparam logic [7:0] CT_MBC3_RAM      = 8'h12;
	localparam logic [7:0] CT_MBC3_RAM_BAT  = 8'h13;
	localparam logic [7:0] CT_MBC5          = 8'h19;
	localparam logic [7:0] CT_MBC5_RAM      = 8'h1A;
	localparam logic [7:0] CT_MBC5_RAM_BAT  = 8'h1B;

	// RAM size codes
	localparam logic [7:0] RC_NONE  = 8'h00;
	localparam logic [7:0] RC_8K    = 8'h02;
	localparam logic [7:0] RC_32K   = 8'h03;
	localparam logic [7:0] RC_128K  = 8'h04;
	localparam logic [7:0] RC_64K   = 8'h05;

	typedef struct packed {
		logic [7:0] run_sum;
		logic [7:0] type_code;
		logic [7:0] rom_code;
		logic [7:0] ram_code;
		logic [7:0] stored_sum;
	} hdr_state_t;

	typedef struct packed {
		logic [8:0] type_ofs;
		logic [8:0] rom_ofs;
		logic [8:0] ram_ofs;
		logic [8:0] sum_ofs;
	} hdr_cfg_t;

	typedef struct packed {
		logic        header_ok;
		logic        type_ok;
		logic        rom_ok;
		logic        ram_ok;
		logic        sum_match;
		logic [2:0]  mapper_kind;
		logic        has_ram;
		logic        has_battery;
		logic        has_timer;
		logic [23:0] rom_bytes;
		logic [17:0] ram_bytes;
	} hdr_result_t;

endpackage

// File: design/chc_accum.sv
module chc_accum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [8:0]          byte_offset,
	input  logic [7:0]          byte_value,
	input  logic                last_byte,
	input  chc_pkg::hdr_cfg_t   cfg,
	output chc_pkg::hdr_state_t merged
);
	import chc_pkg::*;

	hdr_state_t state_q;

	// Fold the current word into the running sum and the captures
	always_comb begin
		merged = state_q;
		if (byte_offset >= SUM_FIRST && byte_offset <= SUM_LAST) begin
			merged.run_sum = state_q.run_sum - byte_value - 8'd1;
		end
		if (byte_offset == cfg.type_ofs) begin
			merged.type_code = byte_value;
		end
		if (byte_offset == cfg.rom_ofs) begin
			merged.rom_code = byte_value;
		end
		if (byte_offset == cfg.ram_ofs) begin
			merged.ram_code = byte_value;
		end
		if (byte_offset == cfg.sum_ofs) begin
			merged.stored_sum = byte_value;
		end
	end

	// Hold the header state; drop it after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= last_byte ? '0 : merged;
		end
	end

endmodule

// File: design/chc_decode.sv
module chc_decode (
	input  chc_pkg::hdr_state_t  hdr,
	output chc_pkg::hdr_result_t res
);
	import chc_pkg::*;

	logic        type_ok;
	logic [2:0]  kind;
	logic        ram_f;
	logic        bat_f;
	logic        tim_f;
	logic        rom_ok;
	logic        ram_code_ok;
	logic [17:0] ram_len;

	// Decode the cartridge type
	always_comb begin
		type_ok = 1'b1;
		kind    = MK_NONE;
		ram_f   = 1'b0;
		bat_f   = 1'b0;
		tim_f   = 1'b0;
		unique case (hdr.type_code)
			CT_ROM_ONLY: ;
			CT_MBC1: kind = MK_MBC1;
			CT_MBC1_RAM: begin
				kind = MK_MBC1; ram_f = 1'b1;
			end
			CT_MBC1_RAM_BAT: begin
				kind = MK_MBC1; ram_f = 1'b1; bat_f = 1'b1;
			end
			CT_MBC2: kind = MK_MBC2;
			CT_MBC2_BAT: begin
				kind = MK_MBC2; bat_f = 1'b1;
			end
			CT_MBC3_TIM_BAT: begin
				kind = MK_MBC3; tim_f = 1'b1; bat_f = 1'b1;
			end
			CT_MBC3_TIM_RAM_BAT: begin
				kind = MK_MBC3; tim_f = 1'b1; ram_f = 1'b1; bat_f = 1'b1;
			end
			CT_MBC3: kind = MK_MBC3;
			CT_MBC3_RAM: begin
				kind = MK_MBC3; ram_f = 1'b1;
			end
			CT_MBC3_RAM_BAT: begin
				kind = MK_MBC3; ram_f = 1'b1; bat_f = 1'b1;
			end
			CT_MBC5: kind = MK_MBC5;
			CT_MBC5_RAM: begin
				kind = MK_MBC5; ram_f = 1'b1;
			end
			CT_MBC5_RAM_BAT: begin
				kind = MK_MBC5; ram_f = 1'b1; bat_f = 1'b1;
			end
			default: begin
				type_ok = 1'b0;
				kind    = MK_UNSUPPORTED;
			end
		endcase
	end

	// Decode the RAM size code (the 0x02 entry is taken as 8 KiB)
	always_comb begin
		ram_code_ok = 1'b1;
		ram_len     = '0;
		unique case (hdr.ram_code)
			RC_NONE: ram_len = '0;
			RC_8K:   ram_len = 18'd8192;
			RC_32K:  ram_len = 18'd32768;
			RC_128K: ram_len = 18'd131072;
			RC_64K:  ram_len = 18'd65536;
			default: ram_code_ok = 1'b0;
		endcase
	end

	assign rom_ok = hdr.rom_code < ROM_CODE_LIMIT;

	// Assemble the result word
	always_comb begin
		res.type_ok     = type_ok;
		res.rom_ok      = rom_ok;
		res.ram_ok      = ram_f ? ram_code_ok : 1'b1;
		res.header_ok   = type_ok & rom_ok & (ram_f ? ram_code_ok : 1'b1);
		res.sum_match   = hdr.run_sum == hdr.stored_sum;
		res.mapper_kind = kind;
		res.has_ram     = ram_f;
		res.has_battery = bat_f;
		res.has_timer   = tim_f;
		res.rom_bytes   = rom_ok ? (ROM_BASE_BYTES << hdr.rom_code[3:0]) : '0;
		res.ram_bytes   = (ram_f && ram_code_ok) ? ram_len : '0;
	end

endmodule

// File: design/cartridge_header_checker_top.sv
// Cartridge header checker.
// Input channel (in_valid/in_stall): one header word per transfer, made of
// byte_offset, byte_value and last_byte. Words in offsets 0x134..0x14C feed
// an 8-bit checksum; words at the four configured offsets are captured.
// Output channel (out_valid/out_stall): one result word per header, given for
// the input word that carries last_byte, with the decoded type, sizes,
// validity flags and the checksum compare.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 type,
// 1 ROM code, 2 RAM code, 3 stored checksum offset); write only while idle.
// Timing: a word is registered at acceptance and folded into the header
// state as it leaves the input register, where a last word also loads the
// result register. One word is taken every cycle unless in_stall is high;
// the only limit is the single result register.
// Stall: while a result waits, words without last_byte keep flowing; a
// second last word waits in the input register, then in_stall rises.
// Reset: offsets return to 0x147, 0x148, 0x149 and 0x14D, the header state
// clears and both channels go empty. Header state clears after each result.
module cartridge_header_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [8:0]  byte_offset,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        header_ok,
	output logic        type_ok,
	output logic        rom_ok,
	output logic        ram_ok,
	output logic        sum_match,
	output logic [2:0]  mapper_kind,
	output logic        has_ram,
	output logic        has_battery,
	output logic        has_timer,
	output logic [23:0] rom_bytes,
	output logic [17:0] ram_bytes
);
	import chc_pkg::*;

	hdr_cfg_t    cfg_q;
	logic        valid_s1;
	logic [8:0]  offset_s1;
	logic [7:0]  value_s1;
	logic        last_s1;
	logic        out_free;
	logic        move_s1;
	logic        load_s1;
	hdr_state_t  merged;
	hdr_result_t res;
	logic        out_valid_q;
	hdr_result_t result_q;

	// Write the offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.type_ofs <= RST_TYPE_OFS;
			cfg_q.rom_ofs  <= RST_ROM_OFS;
			cfg_q.ram_ofs  <= RST_RAM_OFS;
			cfg_q.sum_ofs  <= RST_SUM_OFS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TYPE_OFS: cfg_q.type_ofs <= cfg_data;
				REG_ROM_OFS:  cfg_q.rom_ofs  <= cfg_data;
				REG_RAM_OFS:  cfg_q.ram_ofs  <= cfg_data;
				REG_SUM_OFS:  cfg_q.sum_ofs  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance a word unless it is a last word with the result slot busy
	assign out_free = !out_valid_q || !out_stall;
	assign move_s1  = valid_s1 && (!last_s1 || out_free);
	assign load_s1  = !valid_s1 || move_s1;
	assign in_stall = !load_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			offset_s1 <= byte_offset;
			value_s1  <= byte_value;
			last_s1   <= last_byte;
		end
	end

	chc_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (move_s1),
		.byte_offset (offset_s1),
		.byte_value  (value_s1),
		.last_byte   (last_s1),
		.cfg         (cfg_q),
		.merged      (merged)
	);

	chc_decode u_decode (
		.hdr (merged),
		.res (res)
	);

	// Result register: load on a last word, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && last_s1) begin
			result_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign header_ok   = result_q.header_ok;
	assign type_ok     = result_q.type_ok;
	assign rom_ok      = result_q.rom_ok;
	assign ram_ok      = result_q.ram_ok;
	assign sum_match   = result_q.sum_match;
	assign mapper_kind = result_q.mapper_kind;
	assign has_ram     = result_q.has_ram;
	assign has_battery = result_q.has_battery;
	assign has_timer   = result_q.has_timer;
	assign rom_bytes   = result_q.rom_bytes;
	assign ram_bytes   = result_q.ram_bytes;

endmodule

// File: design/chc_checker.sv
`include "assert_macros.svh"

module chc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        header_ok,
	input logic        type_ok,
	input logic        rom_ok,
	input logic        ram_ok,
	input logic [2:0]  mapper_kind,
	input logic        has_ram,
	input logic        has_battery,
	input logic        has_timer,
	input logic [23:0] rom_bytes,
	input logic [17:0] ram_bytes
);
	import chc_pkg::*;

	// A stalled result stays presented
	`CHK_ASSERT(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> out_valid, "result dropped while stalled")

	// Overall verdict is the conjunction of the three checks
	`CHK_ASSERT_VLD(a_hdr_ok, clk, arst_n, out_valid, header_ok == (type_ok && rom_ok && ram_ok), "header_ok mismatch")

	// Unsupported type clears every feature flag
	`CHK_ASSERT_VLD(a_unsup, clk, arst_n, out_valid && !type_ok, mapper_kind == MK_UNSUPPORTED && !has_ram && !has_battery && !has_timer, "unsupported type decode")

	// ROM size is zero where its code is invalid, RAM size where RAM is absent
	`CHK_ASSERT_VLD(a_sizes, clk, arst_n, out_valid, (rom_ok || rom_bytes == '0) && (has_ram || (ram_ok && ram_bytes == '0)), "size fields inconsistent")

endmodule

bind cartridge_header_checker_top chc_checker u_chc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.header_ok   (header_ok),
	.type_ok     (type_ok),
	.rom_ok      (rom_ok),
	.ram_ok      (ram_ok),
	.mapper_kind (mapper_kind),
	.has_ram     (has_ram),
	.has_battery (has_battery),
	.has_timer   (has_timer),
	.rom_bytes   (rom_bytes),
	.ram_bytes   (ram_bytes)
);
